[hw/rtl/lnds_pkg.sv]
// Shared types and constants for the longest non-decreasing subsequence unit.
package lnds_pkg;

  localparam int MAX_ITEMS = 64;  // elements kept per sequence
  localparam int IDX_W     = 6;   // element index width
  localparam int CNT_W     = 7;   // element, pile and pick count width

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               final_item;
  } lnds_in_t;

  typedef struct packed {
    logic [5:0] position;
    logic [6:0] run_length;
    logic       end_of_run;
  } lnds_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic ins;       // insert the input value
    logic tb_init;   // start trace-back
    logic tb_step;   // examine one stored element
    logic emit;      // drive one result
    logic clr;       // clear counts
  } lnds_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic tb_done;   // trace-back finished
    logic emit_last; // current result is the last one
    logic none;      // nothing picked
  } lnds_sts_t;

endpackage

[hw/rtl/lnds_ctrl.sv]
// Controller state machine of the subsequence unit.
module lnds_ctrl
  import lnds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      final_i,
  input  lnds_sts_t sts_i,
  output lnds_cmd_t cmd_o,
  output logic      busy_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_TRACE = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.ins = 1'b1;
          if (final_i) begin
            cmd_o.tb_init = 1'b1;
            state_d = S_TRACE;
          end
        end
      end
      S_TRACE: begin
        if (sts_i.tb_done) begin
          if (sts_i.none) begin
            cmd_o.clr = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_EMIT;
          end
        end else begin
          cmd_o.tb_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_last) begin
          cmd_o.clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[hw/rtl/lnds_datapath.sv]
// Datapath of the subsequence unit and the generic registered-read RAM it uses.
module lnds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

module lnds_datapath
  import lnds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lnds_in_t  in_i,
  input  lnds_cmd_t cmd_i,
  output lnds_sts_t sts_o,
  output lnds_out_t out_o
);

  localparam int EW = 32 + IDX_W;  // element entry: biased value and pile

  logic [31:0]      tail_q [MAX_ITEMS];
  logic [CNT_W-1:0] tcnt_q, ecnt_q;

  // trace-back state
  logic [31:0]      bound_q;
  logic [CNT_W-1:0] j_q;       // next element to read is j_q-1
  logic [CNT_W-1:0] p_q;       // pile sought is p_q-1
  logic [CNT_W-1:0] before_q;  // scan restart when a pile has no match
  logic [CNT_W-1:0] pick_q;
  logic [CNT_W-1:0] ocnt_q;    // results left to emit
  logic             rd_vld_q;  // element read data valid
  logic [IDX_W-1:0] rd_idx_q;  // index of the element on the read port

  logic [31:0]      biased;
  logic [CNT_W-1:0] k;
  logic             ins_ok;
  logic [EW-1:0]    elem_rdata;
  logic [31:0]      elem_val;
  logic [IDX_W-1:0] elem_pile;
  logic             issue;
  logic             skip;
  logic             hit;
  logic [IDX_W-1:0] chos_raddr;
  logic [IDX_W-1:0] chos_rdata;

  assign biased = {~in_i.sample_value[31], in_i.sample_value[30:0]};

  // upper bound: first tail strictly greater than the value
  always_comb begin
    k = tcnt_q;
    for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < tcnt_q && tail_q[i] > biased) k = CNT_W'(i);
    end
  end

  assign ins_ok = cmd_i.ins && (ecnt_q < CNT_W'(MAX_ITEMS));

  // element store: value and pile, read one per cycle from the newest down
  lnds_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk_i,
    .we_i   (ins_ok),
    .waddr_i(IDX_W'(ecnt_q)),
    .wdata_i({biased, IDX_W'(k)}),
    .raddr_i(IDX_W'(j_q - CNT_W'(1))),
    .rdata_o(elem_rdata)
  );

  assign {elem_val, elem_pile} = elem_rdata;

  assign issue = cmd_i.tb_step && (j_q != '0);
  assign skip  = cmd_i.tb_step && (j_q == '0) && !rd_vld_q;
  assign hit   = cmd_i.tb_step && rd_vld_q &&
                 (CNT_W'(elem_pile) == p_q - CNT_W'(1)) && (elem_val <= bound_q);

  // picks, newest first; read ahead so each emit cycle has its position
  assign chos_raddr = IDX_W'(ocnt_q - CNT_W'(1) - CNT_W'(cmd_i.emit));

  lnds_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ITEMS)) u_chos_ram (
    .clk_i,
    .we_i   (hit),
    .waddr_i(IDX_W'(pick_q)),
    .wdata_i(rd_idx_q),
    .raddr_i(chos_raddr),
    .rdata_o(chos_rdata)
  );

  assign sts_o.tb_done   = (p_q == '0);
  assign sts_o.none      = (pick_q == '0);
  assign sts_o.emit_last = (ocnt_q == CNT_W'(1));

  assign out_o.position   = chos_rdata;
  assign out_o.run_length = pick_q;
  assign out_o.end_of_run = (ocnt_q == CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (ins_ok && k < CNT_W'(MAX_ITEMS)) tail_q[IDX_W'(k)] <= biased;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q <= '0; ecnt_q <= '0; bound_q <= '0; j_q <= '0; p_q <= '0;
      before_q <= '0; pick_q <= '0; ocnt_q <= '0; rd_vld_q <= 1'b0; rd_idx_q <= '0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        rd_idx_q <= IDX_W'(j_q - CNT_W'(1));
        j_q      <= j_q - CNT_W'(1);
      end
      if (ins_ok) begin
        ecnt_q <= ecnt_q + CNT_W'(1);
        if (k == tcnt_q) tcnt_q <= tcnt_q + CNT_W'(1);
      end
      if (cmd_i.tb_init) begin
        bound_q <= '1;
        pick_q  <= '0;
        // include the item inserted this very cycle
        if (ins_ok) begin
          j_q      <= ecnt_q + CNT_W'(1);
          before_q <= ecnt_q + CNT_W'(1);
          p_q      <= (k == tcnt_q) ? tcnt_q + CNT_W'(1) : tcnt_q;
        end else begin
          j_q      <= ecnt_q;
          before_q <= ecnt_q;
          p_q      <= tcnt_q;
        end
      end
      if (skip) begin
        p_q <= p_q - CNT_W'(1);
        j_q <= before_q;
      end
      if (hit) begin
        bound_q  <= elem_val;
        pick_q   <= pick_q + CNT_W'(1);
        ocnt_q   <= pick_q + CNT_W'(1);
        p_q      <= p_q - CNT_W'(1);
        before_q <= CNT_W'(rd_idx_q);
      end
      if (cmd_i.emit) ocnt_q <= ocnt_q - CNT_W'(1);
      if (cmd_i.clr) begin
        tcnt_q <= '0;
        ecnt_q <= '0;
      end
    end
  end

endmodule

[hw/rtl/longest_nondecreasing_subsequence_unit.sv]
// Top level of the longest non-decreasing subsequence unit.
// Values enter one per item at a rising edge with start_i high and busy_o low;
// a non-final item's upper bound is found by a parallel compare over the tail
// row, so such items can follow back to back. The final item starts a
// trace-back that reads one stored element per cycle from the newest down:
// the element RAM's registered read, then each element from the last index
// down to the first chosen one, and a closing step. Then the chosen positions
// come out one per cycle on out_o with out_valid_o, ascending, and busy_o
// falls after the last one. The receiver cannot stall: each result is valid
// for exactly one cycle. At most MAX_ITEMS (64) values per sequence are kept;
// extra ones are dropped.
module longest_nondecreasing_subsequence_unit
  import lnds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  lnds_in_t  in_i,
  output logic      busy_o,
  output logic      out_valid_o,
  output lnds_out_t out_o
);

  lnds_cmd_t cmd;
  lnds_sts_t sts;

  lnds_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .final_i(in_i.final_item),
    .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  lnds_datapath u_dp (
    .clk_i, .rst_ni, .in_i, .cmd_i(cmd), .sts_o(sts), .out_o
  );

  assign out_valid_o = cmd.emit;

endmodule

[bench/lnds_checker.sv]
// Checker for the longest non-decreasing subsequence unit: predicts and compares.
module lnds_checker
  import lnds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_o,
  input  lnds_in_t  in_i,
  input  logic      out_valid_o,
  input  lnds_out_t out_o,
  output int        fail_count,
  output int        pending
);

  logic signed [31:0] pile_tops [MAX_ITEMS];
  logic signed [31:0] seq_values [MAX_ITEMS];
  int                 seq_piles [MAX_ITEMS];
  int                 pile_total;
  int                 seq_total;
  lnds_out_t          expected_positions [$];

  assign pending = expected_positions.size();

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Patience insert: first pile top strictly greater than the value.
  task automatic insert_value(input logic signed [31:0] v);
    int k;
    k = 0;
    if (seq_total >= MAX_ITEMS) return;
    while (k < pile_total && pile_tops[k] <= v) k++;
    pile_tops[k] = v;
    if (k == pile_total) pile_total++;
    seq_values[seq_total] = v;
    seq_piles[seq_total] = k;
    seq_total++;
  endtask

  // Walk piles from longest down, queue picks in ascending index order.
  task automatic trace_subsequence();
    int                 picks [$];
    logic signed [31:0] bound;
    int                 limit;
    lnds_out_t          r;
    bound = 32'sh7fff_ffff;
    limit = seq_total;
    for (int p = pile_total - 1; p >= 0; p--) begin
      for (int j = limit - 1; j >= 0; j--) begin
        if (seq_piles[j] == p && seq_values[j] <= bound) begin
          bound = seq_values[j];
          limit = j;
          picks = {j, picks};
          break;
        end
      end
    end
    foreach (picks[i]) begin
      r.position   = picks[i][5:0];
      r.run_length = 7'(picks.size());
      r.end_of_run = (i == picks.size() - 1);
      expected_positions = {expected_positions, r};
    end
    pile_total = 0;
    seq_total = 0;
  endtask

  always @(posedge clk_i) begin
    lnds_out_t want;
    if (!rst_ni) begin
      fail_count = 0;
      pile_total = 0;
      seq_total  = 0;
      expected_positions.delete();
    end else begin
      if (out_valid_o) begin
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("unexpected result pos %0d", out_o.position));
        end else begin
          want = expected_positions.pop_front();
          if (out_o.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d", out_o.position,
                                      want.position));
          if (out_o.run_length !== want.run_length)
            report_mismatch($sformatf("run_length %0d, want %0d", out_o.run_length,
                                      want.run_length));
          if (out_o.end_of_run !== want.end_of_run)
            report_mismatch($sformatf("end_of_run %0b, want %0b", out_o.end_of_run,
                                      want.end_of_run));
        end
      end
      if (start_i && !busy_o) begin
        insert_value(in_i.sample_value);
        if (in_i.final_item) trace_subsequence();
      end
    end
  end

endmodule

[bench/tb.sv]
// Testbench top: stimulus, idling, watchdog and verdict for the subsequence unit.
module tb;
  import lnds_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 470;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  lnds_in_t  in_i;
  logic      busy_o;
  logic      out_valid_o;
  lnds_out_t out_o;
  int        fail_count;
  int        pending;
  int        idle_pct;
  int        quiet_cycles;
  int        items_sent;

  longest_nondecreasing_subsequence_unit i_dut (
    .clk_i, .rst_ni, .start_i, .in_i, .busy_o, .out_valid_o, .out_o
  );

  lnds_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .out_valid_o, .out_o,
    .fail_count, .pending
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Watchdog: cycles without any accepted item or result.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || out_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one item from a falling edge; hold until the block takes it.
  task automatic send_item(input logic signed [31:0] v, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      in_i    <= '{sample_value: 32'($urandom), final_item: 1'($urandom)};
      @(negedge clk_i);
    end
    start_i           <= 1'b1;
    in_i.sample_value <= v;
    in_i.final_item   <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value(input int style);
    case (style)
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(8)) - 4);
      default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  task automatic send_sequence(input int len, input int style);
    for (int i = 0; i < len; i++) send_item(pick_value(style), i == len - 1);
  endtask

  initial begin
    logic signed [31:0] mix [$];
    int                 len;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    in_i         = '0;
    idle_pct     = 0;
    items_sent   = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single extremes, ties, falling run, alternating extremes.
    send_item(32'sh7fff_ffff, 1'b1);
    send_item(32'sh8000_0000, 1'b1);
    send_item(5, 1'b0); send_item(5, 1'b0); send_item(5, 1'b1);
    send_item(3, 1'b0); send_item(2, 1'b0); send_item(1, 1'b0); send_item(0, 1'b1);
    mix = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0,
            -1, 0, -1, 2, 2, 1};
    foreach (mix[i]) send_item(mix[i], i == mix.size() - 1);

    // Random sequences in three idling phases; a few overflow past capacity.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) idle_pct = 32;
      else if (items_sent < 2 * RANDOM_ITEMS / 3) idle_pct = 47;
      else idle_pct = 0;
      len = ($urandom_range(99) < 6) ? $urandom_range(70, 60) : $urandom_range(16, 1);
      send_sequence(len, $urandom_range(99) < 45 ? 0 : ($urandom_range(99) < 80 ? 1 : 2));
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
